/* hdl/i2c_sbs_pkg.sv */
// Package for the I2C slave byte sequencer: item types, phase and mode codes,
// counter presets and the phase-to-mode encoder. No dependencies.
package i2c_sbs_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgOwnAddress = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReplyByte  = 2'd1;

  localparam logic [0:0] OpStart    = 1'b0;
  localparam logic [0:0] OpOverflow = 1'b1;

  localparam logic [3:0] PresetByte = 4'h0;
  localparam logic [3:0] PresetAck  = 4'hE;

  localparam logic [2:0] ModeAddress  = 3'd0;
  localparam logic [2:0] ModeMWrite   = 3'd1;
  localparam logic [2:0] ModeReceive  = 3'd2;
  localparam logic [2:0] ModeMRead    = 3'd3;
  localparam logic [2:0] ModeTransmit = 3'd4;

  typedef enum logic [4:0] {
    PhAddress  = 5'b00001,
    PhMWrite   = 5'b00010,
    PhReceive  = 5'b00100,
    PhMRead    = 5'b01000,
    PhTransmit = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [0:0] operation;
    logic [7:0] shift_byte;
    logic [0:0] clock_line_high;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode_after;
    logic [0:0] data_pin_output;
    logic [0:0] data_pin_level;
    logic [3:0] counter_preset;
    logic [7:0] shift_load;
    logic [0:0] overflow_enabled;
    logic [0:0] went_idle;
    logic [7:0] received_data;
    logic [0:0] received_strobe;
  } out_item_t;

  function automatic logic [2:0] phase_to_mode(phase_e ph);
    logic [2:0] m;
    case (ph)
      PhAddress:  m = ModeAddress;
      PhMWrite:   m = ModeMWrite;
      PhReceive:  m = ModeReceive;
      PhMRead:    m = ModeMRead;
      PhTransmit: m = ModeTransmit;
      default:    m = ModeAddress;
    endcase
    return m;
  endfunction

endpackage

/* hdl/i2c_slave_byte_sequencer_unit.sv */
// I2C slave byte sequencer: per-event state update between an input register
// and a result register. Depends on i2c_sbs_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one bus event
//   per item: a start condition or a counter overflow with the shifted byte,
//   plus the SCL level seen after the wait. Every item yields one result item
//   on the output channel (out_valid_o / out_stall_i / out_item_o).
//   Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is the own address (low 7 bits), index 1 the reply byte, others
//   are ignored. cfg_ready_o is always high; write only while idle.
//   Path: the item is held in the input register, decoded, and its result
//   loaded into the result register once the output is free. Throughput:
//   one item per cycle when not stalled; all event decode is combinational.
//   Reset: phase goes to address mode, overflow events disarmed, shift and
//   captured byte cleared, SDA released as input; both registers empty.
//   Stall: a stalled result holds; the input register keeps taking items
//   until it is full behind the stalled result, then in_stall_o rises.
module i2c_slave_byte_sequencer_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [i2c_sbs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [7:0]                           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  i2c_sbs_pkg::in_item_t                in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output i2c_sbs_pkg::out_item_t               out_item_o
);

  logic [6:0] own_addr_q;
  logic [7:0] reply_q;

  logic                  in_vld_q;
  i2c_sbs_pkg::in_item_t in_q;
  logic                   out_vld_q;
  i2c_sbs_pkg::out_item_t out_q;

  i2c_sbs_pkg::phase_e phase_q, phase_d;
  logic       armed_q, armed_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] last_q, last_d;
  logic       sda_oe_q, sda_oe_d;
  logic       sda_lvl_q, sda_lvl_d;
  logic [3:0] preset;
  logic       idle_now;
  logic       strobe;

  logic out_free;
  logic advance;
  logic in_take;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign advance     = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      reply_q    <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == i2c_sbs_pkg::CfgOwnAddress) begin
        own_addr_q <= cfg_data_i[6:0];
      end else if (cfg_index_i == i2c_sbs_pkg::CfgReplyByte) begin
        reply_q <= cfg_data_i;
      end
    end
  end

  // event decode
  always_comb begin
    phase_d   = phase_q;
    armed_d   = armed_q;
    shift_d   = shift_q;
    last_d    = last_q;
    sda_oe_d  = sda_oe_q;
    sda_lvl_d = sda_lvl_q;
    preset    = i2c_sbs_pkg::PresetByte;
    idle_now  = 1'b0;
    strobe    = 1'b0;
    if (in_q.operation == i2c_sbs_pkg::OpStart) begin
      sda_oe_d = 1'b0;
      phase_d  = i2c_sbs_pkg::PhAddress;
      shift_d  = '0;
      armed_d  = !in_q.clock_line_high[0];
      idle_now = in_q.clock_line_high[0];
    end else if (armed_q) begin
      case (phase_q)
        i2c_sbs_pkg::PhAddress: begin
          if (in_q.shift_byte[7:1] == own_addr_q) begin
            phase_d   = in_q.shift_byte[0] ? i2c_sbs_pkg::PhMRead : i2c_sbs_pkg::PhMWrite;
            sda_oe_d  = 1'b1;
            sda_lvl_d = 1'b0;
            preset    = i2c_sbs_pkg::PresetAck;
            shift_d   = '0;
          end else begin
            shift_d  = '0;
            armed_d  = 1'b0;
            idle_now = 1'b1;
          end
        end
        i2c_sbs_pkg::PhMWrite: begin
          phase_d  = i2c_sbs_pkg::PhReceive;
          sda_oe_d = 1'b0;
          shift_d  = in_q.shift_byte;
          if (in_q.clock_line_high[0]) begin
            shift_d  = '0;
            armed_d  = 1'b0;
            idle_now = 1'b1;
          end
        end
        i2c_sbs_pkg::PhReceive: begin
          phase_d   = i2c_sbs_pkg::PhMWrite;
          last_d    = in_q.shift_byte;
          strobe    = 1'b1;
          shift_d   = in_q.shift_byte;
          sda_oe_d  = 1'b1;
          sda_lvl_d = 1'b0;
          preset    = i2c_sbs_pkg::PresetAck;
        end
        i2c_sbs_pkg::PhMRead: begin
          if (in_q.shift_byte != 8'h00) begin
            shift_d  = '0;
            armed_d  = 1'b0;
            idle_now = 1'b1;
          end else begin
            phase_d   = i2c_sbs_pkg::PhTransmit;
            shift_d   = reply_q;
            sda_oe_d  = 1'b1;
            sda_lvl_d = 1'b1;
          end
        end
        i2c_sbs_pkg::PhTransmit: begin
          phase_d  = i2c_sbs_pkg::PhMRead;
          sda_oe_d = 1'b0;
          shift_d  = '0;
          preset   = i2c_sbs_pkg::PresetAck;
        end
        default: begin
          shift_d  = '0;
          armed_d  = 1'b0;
          idle_now = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2c_sbs_pkg::PhAddress;
      armed_q   <= 1'b0;
      shift_q   <= '0;
      last_q    <= '0;
      sda_oe_q  <= 1'b0;
      sda_lvl_q <= 1'b1;
    end else if (advance) begin
      phase_q   <= phase_d;
      armed_q   <= armed_d;
      shift_q   <= shift_d;
      last_q    <= last_d;
      sda_oe_q  <= sda_oe_d;
      sda_lvl_q <= sda_lvl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q.mode_after       <= i2c_sbs_pkg::phase_to_mode(phase_d);
      out_q.data_pin_output  <= sda_oe_d;
      out_q.data_pin_level   <= sda_lvl_d;
      out_q.counter_preset   <= preset;
      out_q.shift_load       <= shift_d;
      out_q.overflow_enabled <= armed_d;
      out_q.went_idle        <= idle_now;
      out_q.received_data    <= last_d;
      out_q.received_strobe  <= strobe;
    end
  end

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_strobe_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.received_strobe |->
      out_q.mode_after == i2c_sbs_pkg::ModeMWrite && out_q.received_data == out_q.shift_load)
    else $error("captured byte without write phase");

  a_idle_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.went_idle |-> !out_q.overflow_enabled && out_q.shift_load == 8'h00)
    else $error("idle result still armed");

  a_preset_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.counter_preset == i2c_sbs_pkg::PresetByte ||
                  out_q.counter_preset == i2c_sbs_pkg::PresetAck)
    else $error("bad counter preset");

endmodule

/* sim/i2c_slave_byte_sequencer_unit_test.sv */
// Self-checking testbench for i2c_slave_byte_sequencer_unit: bus-event items in,
// one predicted result item out per event. Depends on i2c_sbs_pkg and the unit.
`timescale 1ns / 100ps

module i2c_slave_byte_sequencer_unit_test;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SegmentItems = 57;
  localparam logic [i2c_sbs_pkg::CfgIdxW-1:0] FirstUnusedIdx =
    i2c_sbs_pkg::CfgReplyByte + 1'b1;

  class seq_scoreboard;
    logic [6:0] own_addr;
    logic [7:0] reply;
    logic [2:0] mode;
    logic       armed;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] last_rx;
    logic [7:0] shift;
    logic [3:0] preset;
    logic       idle_flag;
    i2c_sbs_pkg::out_item_t expected_q[$];
    int         errors;

    function new();
      own_addr  = 7'h00;
      reply     = 8'h00;
      mode      = i2c_sbs_pkg::ModeAddress;
      armed     = 1'b0;
      sda_drive = 1'b0;
      sda_level = 1'b1;
      last_rx   = 8'h00;
      shift     = 8'h00;
      errors    = 0;
    endfunction

    function void set_register(logic [i2c_sbs_pkg::CfgIdxW-1:0] idx, logic [7:0] data);
      if (idx == i2c_sbs_pkg::CfgOwnAddress) begin
        own_addr = data[6:0];
      end else if (idx == i2c_sbs_pkg::CfgReplyByte) begin
        reply = data;
      end
    endfunction

    function void enter_start_wait();
      preset    = i2c_sbs_pkg::PresetByte;
      shift     = 8'h00;
      armed     = 1'b0;
      idle_flag = 1'b1;
    endfunction

    function void note_event(i2c_sbs_pkg::in_item_t it);
      i2c_sbs_pkg::out_item_t r;
      logic      rx_strobe;
      preset    = i2c_sbs_pkg::PresetByte;
      idle_flag = 1'b0;
      rx_strobe = 1'b0;
      if (it.operation == i2c_sbs_pkg::OpStart) begin
        sda_drive = 1'b0;
        mode      = i2c_sbs_pkg::ModeAddress;
        enter_start_wait();
        if (!it.clock_line_high) begin
          armed     = 1'b1;
          idle_flag = 1'b0;
        end
      end else if (armed) begin
        case (mode)
          i2c_sbs_pkg::ModeAddress: begin
            if (it.shift_byte[7:1] == own_addr) begin
              mode      = it.shift_byte[0] ? i2c_sbs_pkg::ModeMRead
                                           : i2c_sbs_pkg::ModeMWrite;
              sda_drive = 1'b1;
              sda_level = 1'b0;
              preset    = i2c_sbs_pkg::PresetAck;
              shift     = 8'h00;
            end else begin
              enter_start_wait();
            end
          end
          i2c_sbs_pkg::ModeMWrite: begin
            mode      = i2c_sbs_pkg::ModeReceive;
            sda_drive = 1'b0;
            shift     = it.shift_byte;
            if (it.clock_line_high) enter_start_wait();
          end
          i2c_sbs_pkg::ModeReceive: begin
            mode      = i2c_sbs_pkg::ModeMWrite;
            last_rx   = it.shift_byte;
            rx_strobe = 1'b1;
            shift     = it.shift_byte;
            sda_drive = 1'b1;
            sda_level = 1'b0;
            preset    = i2c_sbs_pkg::PresetAck;
          end
          i2c_sbs_pkg::ModeMRead: begin
            if (it.shift_byte != 8'h00) begin
              enter_start_wait();
            end else begin
              mode      = i2c_sbs_pkg::ModeTransmit;
              shift     = reply;
              sda_drive = 1'b1;
              sda_level = 1'b1;
            end
          end
          i2c_sbs_pkg::ModeTransmit: begin
            mode      = i2c_sbs_pkg::ModeMRead;
            sda_drive = 1'b0;
            shift     = 8'h00;
            preset    = i2c_sbs_pkg::PresetAck;
          end
          default: begin
            enter_start_wait();
          end
        endcase
      end
      r.mode_after       = mode;
      r.data_pin_output  = sda_drive;
      r.data_pin_level   = sda_level;
      r.counter_preset   = preset;
      r.shift_load       = shift;
      r.overflow_enabled = armed;
      r.went_idle        = idle_flag;
      r.received_data    = last_rx;
      r.received_strobe  = rx_strobe;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] got);
      if (got !== exp) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, exp, got);
      end
    endfunction

    function void check_result(i2c_sbs_pkg::out_item_t got);
      i2c_sbs_pkg::out_item_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none got %h", $time, got);
        return;
      end
      exp = expected_q.pop_front();
      compare_field("mode_after", 8'(exp.mode_after), 8'(got.mode_after));
      compare_field("data_pin_output", 8'(exp.data_pin_output), 8'(got.data_pin_output));
      compare_field("data_pin_level", 8'(exp.data_pin_level), 8'(got.data_pin_level));
      compare_field("counter_preset", 8'(exp.counter_preset), 8'(got.counter_preset));
      compare_field("shift_load", exp.shift_load, got.shift_load);
      compare_field("overflow_enabled", 8'(exp.overflow_enabled),
                    8'(got.overflow_enabled));
      compare_field("went_idle", 8'(exp.went_idle), 8'(got.went_idle));
      compare_field("received_data", exp.received_data, got.received_data);
      compare_field("received_strobe", 8'(exp.received_strobe), 8'(got.received_strobe));
    endfunction
  endclass

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [i2c_sbs_pkg::CfgIdxW-1:0]    cfg_index_i = '0;
  logic [7:0]                         cfg_data_i  = 8'h00;
  logic                               in_valid_i  = 1'b0;
  logic                               in_stall_o;
  i2c_sbs_pkg::in_item_t              in_item_i   = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  i2c_sbs_pkg::out_item_t             out_item_o;

  seq_scoreboard board;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int events_sent    = 0;
  int quiet_cycles   = 0;

  i2c_slave_byte_sequencer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_item_o);
      if (in_valid_i && !in_stall_o) board.note_event(in_item_i);
      if (cfg_valid_i && cfg_ready_o) board.set_register(cfg_index_i, cfg_data_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("i2c_slave_byte_sequencer_unit_test NOT OK");
        $finish;
      end
    end
  end

  task automatic send(logic [0:0] op, logic [7:0] data, logic [0:0] scl);
    i2c_sbs_pkg::in_item_t it;
    it.operation       = op;
    it.shift_byte      = data;
    it.clock_line_high = scl;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    events_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);
  endtask

  task automatic write_reg(logic [i2c_sbs_pkg::CfgIdxW-1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(logic [6:0] addr, logic [7:0] reply);
    write_reg(i2c_sbs_pkg::CfgOwnAddress, {1'($urandom_range(1)), addr});
    write_reg(i2c_sbs_pkg::CfgReplyByte, reply);
    write_reg(FirstUnusedIdx + i2c_sbs_pkg::CfgIdxW'($urandom_range(1)),
              8'($urandom_range(255)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_transaction();
    int         pick;
    logic [6:0] addr;
    addr = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : board.own_addr;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send(i2c_sbs_pkg::OpStart, 8'($urandom_range(255)), 1'b0);
      send(i2c_sbs_pkg::OpOverflow, {addr, 1'b0}, 1'($urandom_range(1)));
      repeat ($urandom_range(1, 4)) begin
        send(i2c_sbs_pkg::OpOverflow, 8'($urandom_range(255)), 1'b0);
        send(i2c_sbs_pkg::OpOverflow, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      if ($urandom_range(1) != 0) begin
        send(i2c_sbs_pkg::OpOverflow, 8'($urandom_range(255)), 1'b1);
      end
    end else if (pick < 75) begin
      send(i2c_sbs_pkg::OpStart, 8'($urandom_range(255)), 1'b0);
      send(i2c_sbs_pkg::OpOverflow, {addr, 1'b1}, 1'($urandom_range(1)));
      repeat ($urandom_range(0, 3)) begin
        send(i2c_sbs_pkg::OpOverflow, 8'h00, 1'($urandom_range(1)));
        send(i2c_sbs_pkg::OpOverflow, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      if ($urandom_range(3) != 0) begin
        send(i2c_sbs_pkg::OpOverflow, 8'($urandom_range(1, 255)), 1'($urandom_range(1)));
      end
    end else if (pick < 85) begin
      send(i2c_sbs_pkg::OpStart, 8'($urandom_range(255)), 1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int seg_start;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    apply_settings(7'h7F, 8'hFF);

    // overflow before any start, stop, mismatch, write, read with nack
    send(i2c_sbs_pkg::OpOverflow, 8'hFF, 1'b1);
    send(i2c_sbs_pkg::OpStart,    8'h00, 1'b1);
    send(i2c_sbs_pkg::OpOverflow, 8'h00, 1'b0);
    send(i2c_sbs_pkg::OpStart,    8'hFF, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'h00, 1'b0);
    send(i2c_sbs_pkg::OpStart,    8'h00, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'hFE, 1'b1);
    send(i2c_sbs_pkg::OpOverflow, 8'h12, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'hFF, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'h00, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'h00, 1'b1);
    send(i2c_sbs_pkg::OpOverflow, 8'h34, 1'b1);
    send(i2c_sbs_pkg::OpOverflow, 8'h56, 1'b0);
    send(i2c_sbs_pkg::OpStart,    8'h00, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'hFF, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'h00, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'hAA, 1'b1);
    send(i2c_sbs_pkg::OpOverflow, 8'h00, 1'b1);
    send(i2c_sbs_pkg::OpOverflow, 8'h7F, 1'b0);
    send(i2c_sbs_pkg::OpOverflow, 8'h01, 1'b0);
    send(i2c_sbs_pkg::OpStart,    8'h00, 1'b1);

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_gap_pct   = 13;
          recv_stall_pct = 66;
        end
        1: begin
          send_gap_pct   = 66;
          recv_stall_pct = 13;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        drain();
        case ((regime * 3 + seg) % 4)
          0: apply_settings(7'h00, 8'h00);
          1: apply_settings(7'h7F, 8'hFF);
          default: apply_settings(7'($urandom_range(127)), 8'($urandom_range(255)));
        endcase
        seg_start = events_sent;
        while (events_sent - seg_start < SegmentItems) begin
          if ($urandom_range(19) == 0) drain();
          run_transaction();
        end
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("i2c_slave_byte_sequencer_unit_test OK");
    end else begin
      $display("i2c_slave_byte_sequencer_unit_test NOT OK");
    end
    $finish;
  end

endmodule
